@@ rtl/vkc_pkg.sv @@
// voxel key codec package: widths, register indexes and pipeline stage types
// used by voxel_key_codec_top; no dependencies
`timescale 1ns / 1ps

package vkc_pkg;

    // field and datapath widths
    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 31;
    localparam int STEP_W    = 10;
    localparam int RAD_W     = 11;
    localparam int RR_W      = 21;
    localparam int KEY_W     = 31;
    localparam int IDX_W     = 11;
    localparam int XIDX_W    = 18;
    localparam int EREM_W    = 34;
    localparam int DEN_W     = 32;
    localparam int PROD_W    = 50;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // divider schedule: encode steps run alongside the first decode steps
    localparam int ENC_STEPS = IDX_W;
    localparam int DX_STEPS  = XIDX_W;
    localparam int DIV_STEPS = XIDX_W + IDX_W;

    localparam int RADIX_BIAS    = 100;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_MAX_STEP  = 1023;
    localparam int STEP_RESET    = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd6;

    // raw item as taken from the input channel
    typedef struct packed {
        logic                              func;
        logic [2:0][COORD_W-1:0]           pt;
        logic [COORD_W-1:0]                key;
    } t_in;

    // offsets from the origin, clipped at zero
    typedef struct packed {
        logic                              func;
        logic                              neg;
        logic [2:0][COORD_W-1:0]           mag;
        logic [KEY_W-1:0]                  krem;
    } t_pa;

    // divider stage: encode remainders and quotients, decode remainder and indexes
    typedef struct packed {
        logic                              func;
        logic                              neg;
        logic [2:0][EREM_W-1:0]            erem;
        logic [2:0]                        ovf;
        logic [2:0][IDX_W-1:0]             eq;
        logic [KEY_W-1:0]                  krem;
        logic [XIDX_W-1:0]                 qx;
        logic [IDX_W-1:0]                  qy;
    } t_div;

    // clamped indexes and centre products
    typedef struct packed {
        logic                              func;
        logic                              neg;
        logic [2:0][IDX_W-1:0]             eidx;
        logic [2:0][PROD_W-1:0]            prod;
    } t_m1;

    // key partial products and saturated centres
    typedef struct packed {
        logic                              func;
        logic                              neg;
        logic [31:0]                       p1;
        logic [21:0]                       p2;
        logic [IDX_W-1:0]                  iz;
        logic [2:0][COORD_W-1:0]           cen;
    } t_m2;

endpackage

@@ rtl/voxel_key_codec_top.sv @@
// voxel key codec: point to linear voxel key and key to voxel centre
// pipelined restoring dividers, one quotient bit per stage; uses vkc_pkg
`timescale 1ns / 1ps

// path: input, offset, divider, clamp/product and key/centre registers, then the output register
// throughput: one item per cycle while the output is not stalled, set by the 29 single-bit divider stages
// stalls collapse bubbles stage by stage, so items keep entering while a result waits
// reset (synchronous, active low) empties the pipeline and loads register defaults
// configuration derived values are registered: radix from the step register, squared radix from the radix
module voxel_key_codec_top #(
    parameter int FRAC_BITS = vkc_pkg::DEF_FRAC_BITS,
    parameter int MAX_STEP  = vkc_pkg::DEF_MAX_STEP
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [vkc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [vkc_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic signed [vkc_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [vkc_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [vkc_pkg::COORD_W-1:0]   i_point_z,
    input  logic signed [vkc_pkg::COORD_W-1:0]   i_key_in,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [vkc_pkg::KEY_W-1:0]            o_key_out,
    output logic signed [vkc_pkg::COORD_W-1:0]   o_centre_x,
    output logic signed [vkc_pkg::COORD_W-1:0]   o_centre_y,
    output logic signed [vkc_pkg::COORD_W-1:0]   o_centre_z
);

    localparam int S_IN   = 0;
    localparam int S_PA   = 1;
    localparam int S_DIV0 = 2;
    localparam int S_M1   = S_DIV0 + vkc_pkg::DIV_STEPS + 1;
    localparam int S_M2   = S_M1 + 1;
    localparam int S_OUT  = S_M2 + 1;
    localparam int NS     = S_OUT + 1;

    // configuration registers
    logic signed [2:0][vkc_pkg::COORD_W-1:0] r_org;
    logic [2:0][vkc_pkg::SIZE_W-1:0]         r_size;
    logic [vkc_pkg::STEP_W-1:0]              r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org  <= '0;
            for (int a = 0; a < 3; a++) begin
                r_size[a] <= vkc_pkg::SIZE_W'(1) << FRAC_BITS;
            end
            r_step <= vkc_pkg::STEP_W'(vkc_pkg::STEP_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vkc_pkg::REG_ORIGIN_X: r_org[0]  <= i_cfg_data;
                vkc_pkg::REG_ORIGIN_Y: r_org[1]  <= i_cfg_data;
                vkc_pkg::REG_ORIGIN_Z: r_org[2]  <= i_cfg_data;
                vkc_pkg::REG_SIZE_X:   r_size[0] <= i_cfg_data[vkc_pkg::SIZE_W-1:0];
                vkc_pkg::REG_SIZE_Y:   r_size[1] <= i_cfg_data[vkc_pkg::SIZE_W-1:0];
                vkc_pkg::REG_SIZE_Z:   r_size[2] <= i_cfg_data[vkc_pkg::SIZE_W-1:0];
                vkc_pkg::REG_STEP:     r_step    <= i_cfg_data[vkc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // derived grid constants: radix, radix squared, effective sizes
    logic [vkc_pkg::STEP_W-1:0]             n_step;
    logic [vkc_pkg::RAD_W-1:0]              r_rad;
    logic [vkc_pkg::RAD_W-1:0]              r_rm1;
    logic [vkc_pkg::RR_W-1:0]               r_rr;
    logic [2:0][vkc_pkg::SIZE_W-1:0]        r_es;
    logic [2:0][vkc_pkg::DEN_W-1:0]         w_den;

    always_comb begin
        if (r_step == '0) begin
            n_step = vkc_pkg::STEP_W'(1);
        end else if (r_step > vkc_pkg::STEP_W'(MAX_STEP)) begin
            n_step = vkc_pkg::STEP_W'(MAX_STEP);
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad <= vkc_pkg::RAD_W'(n_step) + vkc_pkg::RAD_W'(vkc_pkg::RADIX_BIAS);
        r_rm1 <= vkc_pkg::RAD_W'(n_step) + vkc_pkg::RAD_W'(vkc_pkg::RADIX_BIAS - 1);
        r_rr  <= vkc_pkg::RR_W'(r_rad) * vkc_pkg::RR_W'(r_rad);
        for (int a = 0; a < 3; a++) begin
            r_es[a] <= (r_size[a] == '0) ? vkc_pkg::SIZE_W'(1) : r_size[a];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_den[a] = {r_es[a], 1'b0};
        end
    end

    // stage advance chain: a stage loads when empty or when its successor moves
    logic [NS-1:0] r_v;
    logic [NS:0]   w_mv;

    always_comb begin
        w_mv[NS] = !i_stall;
        for (int i = NS - 1; i >= 0; i--) begin
            w_mv[i] = !r_v[i] || w_mv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_mv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_mv[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign o_stall = !w_mv[0];
    assign o_valid = r_v[S_OUT];

    // input register
    vkc_pkg::t_in r_in;

    always_ff @(posedge i_clk) begin
        if (w_mv[S_IN]) begin
            r_in.func  <= i_func;
            r_in.pt[0] <= i_point_x;
            r_in.pt[1] <= i_point_y;
            r_in.pt[2] <= i_point_z;
            r_in.key   <= i_key_in;
        end
    end

    // offset from origin; non-positive offsets index voxel zero
    vkc_pkg::t_pa n_pa;
    vkc_pkg::t_pa r_pa;

    always_comb begin
        logic signed [vkc_pkg::COORD_W:0] d;
        n_pa.func = r_in.func;
        n_pa.neg  = r_in.key[vkc_pkg::COORD_W-1];
        n_pa.krem = r_in.key[vkc_pkg::KEY_W-1:0];
        for (int a = 0; a < 3; a++) begin
            d = $signed({r_in.pt[a][vkc_pkg::COORD_W-1], r_in.pt[a]})
              - $signed({r_org[a][vkc_pkg::COORD_W-1], r_org[a]});
            if (d[vkc_pkg::COORD_W] || (d == '0)) begin
                n_pa.mag[a] = '0;
            end else begin
                n_pa.mag[a] = d[vkc_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[S_PA]) begin
            r_pa <= n_pa;
        end
    end

    localparam int IDX_SH = vkc_pkg::IDX_W;

    // rounding numerator 2*mag + size, divided by 2*size below
    vkc_pkg::t_div n_d0;
    vkc_pkg::t_div r_div [0:vkc_pkg::DIV_STEPS];
    vkc_pkg::t_div n_div [0:vkc_pkg::DIV_STEPS-1];

    always_comb begin
        n_d0      = '0;
        n_d0.func = r_pa.func;
        n_d0.neg  = r_pa.neg;
        n_d0.krem = r_pa.krem;
        for (int a = 0; a < 3; a++) begin
            n_d0.erem[a] = {1'b0, r_pa.mag[a], 1'b0} + {3'b000, r_es[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[S_DIV0]) begin
            r_div[0] <= n_d0;
        end
    end

    // one quotient bit per stage for each divider
    for (genvar j = 0; j < vkc_pkg::DIV_STEPS; j++) begin : g_div
        if (j < vkc_pkg::ENC_STEPS && j < vkc_pkg::DX_STEPS) begin : g_enc_x
            localparam int EB = vkc_pkg::ENC_STEPS - 1 - j;
            localparam int XB = vkc_pkg::DX_STEPS - 1 - j;
            always_comb begin
                logic [43:0] eshift;
                logic [39:0] kshift;
                n_div[j] = r_div[j];
                for (int a = 0; a < 3; a++) begin
                    eshift = {12'd0, w_den[a]} << EB;
                    if ({10'd0, r_div[j].erem[a]} >= eshift) begin
                        n_div[j].erem[a] = vkc_pkg::EREM_W'({10'd0, r_div[j].erem[a]} - eshift);
                        n_div[j].eq[a][EB] = 1'b1;
                    end
                    if (j == 0) begin
                        n_div[j].ovf[a] = ({9'd0, r_div[j].erem[a][vkc_pkg::EREM_W-1:IDX_SH]}
                                           >= w_den[a]);
                    end
                end
                kshift = {19'd0, r_rr} << XB;
                if ({9'd0, r_div[j].krem} >= kshift) begin
                    n_div[j].krem = vkc_pkg::KEY_W'({9'd0, r_div[j].krem} - kshift);
                    n_div[j].qx[XB] = 1'b1;
                end
            end
        end else if (j < vkc_pkg::DX_STEPS) begin : g_x
            localparam int XB = vkc_pkg::DX_STEPS - 1 - j;
            always_comb begin
                logic [39:0] kshift;
                n_div[j] = r_div[j];
                kshift = {19'd0, r_rr} << XB;
                if ({9'd0, r_div[j].krem} >= kshift) begin
                    n_div[j].krem = vkc_pkg::KEY_W'({9'd0, r_div[j].krem} - kshift);
                    n_div[j].qx[XB] = 1'b1;
                end
            end
        end else begin : g_y
            localparam int YB = vkc_pkg::DIV_STEPS - 1 - j;
            always_comb begin
                logic [39:0] kshift;
                n_div[j] = r_div[j];
                kshift = {29'd0, r_rad} << YB;
                if ({9'd0, r_div[j].krem} >= kshift) begin
                    n_div[j].krem = vkc_pkg::KEY_W'({9'd0, r_div[j].krem} - kshift);
                    n_div[j].qy[YB] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_mv[S_DIV0+1+j]) begin
                r_div[j+1] <= n_div[j];
            end
        end
    end

    // clamp encode indexes; form (2*index+1)*size for decode
    vkc_pkg::t_m1 n_m1;
    vkc_pkg::t_m1 r_m1;

    always_comb begin
        logic [2:0][vkc_pkg::PROD_W-1:0] odd;
        n_m1.func = r_div[vkc_pkg::DIV_STEPS].func;
        n_m1.neg  = r_div[vkc_pkg::DIV_STEPS].neg;
        odd[0] = vkc_pkg::PROD_W'({r_div[vkc_pkg::DIV_STEPS].qx, 1'b1});
        odd[1] = vkc_pkg::PROD_W'({r_div[vkc_pkg::DIV_STEPS].qy, 1'b1});
        odd[2] = vkc_pkg::PROD_W'({r_div[vkc_pkg::DIV_STEPS].krem[vkc_pkg::IDX_W-1:0], 1'b1});
        for (int a = 0; a < 3; a++) begin
            if (r_div[vkc_pkg::DIV_STEPS].ovf[a]
                || (r_div[vkc_pkg::DIV_STEPS].eq[a] > r_rm1)) begin
                n_m1.eidx[a] = r_rm1;
            end else begin
                n_m1.eidx[a] = r_div[vkc_pkg::DIV_STEPS].eq[a];
            end
            n_m1.prod[a] = odd[a] * vkc_pkg::PROD_W'(r_es[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[S_M1]) begin
            r_m1 <= n_m1;
        end
    end

    // key partial products; centre halving, origin add and saturation
    vkc_pkg::t_m2 n_m2;
    vkc_pkg::t_m2 r_m2;

    always_comb begin
        logic [vkc_pkg::PROD_W-1:0] half;
        logic signed [51:0]         sum;
        n_m2.func = r_m1.func;
        n_m2.neg  = r_m1.neg;
        n_m2.p1   = 32'(r_m1.eidx[0]) * 32'(r_rr);
        n_m2.p2   = 22'(r_m1.eidx[1]) * 22'(r_rad);
        n_m2.iz   = r_m1.eidx[2];
        for (int a = 0; a < 3; a++) begin
            half = vkc_pkg::PROD_W'(({1'b0, r_m1.prod[a]} + 51'd1) >> 1);
            sum  = $signed({2'b00, half}) + 52'($signed(r_org[a]));
            if (sum[51] && !(&sum[50:31])) begin
                n_m2.cen[a] = 32'h8000_0000;
            end else if (!sum[51] && (|sum[50:31])) begin
                n_m2.cen[a] = 32'h7FFF_FFFF;
            end else begin
                n_m2.cen[a] = sum[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[S_M2]) begin
            r_m2 <= n_m2;
        end
    end

    // output register: final key sum and unused-field zeroing
    logic [vkc_pkg::KEY_W-1:0]           r_key;
    logic [2:0][vkc_pkg::COORD_W-1:0]    r_cen;

    always_ff @(posedge i_clk) begin
        if (w_mv[S_OUT]) begin
            if (r_m2.func) begin
                r_key <= '0;
            end else begin
                r_key <= vkc_pkg::KEY_W'(r_m2.p1 + {10'd0, r_m2.p2} + {21'd0, r_m2.iz});
            end
            for (int a = 0; a < 3; a++) begin
                r_cen[a] <= (r_m2.func && !r_m2.neg) ? r_m2.cen[a] : '0;
            end
        end
    end

    assign o_key_out  = r_key;
    assign o_centre_x = r_cen[0];
    assign o_centre_y = r_cen[1];
    assign o_centre_z = r_cen[2];

`ifndef NO_ASSERTIONS
    // a nonzero key means an encode item, whose centres are zero
    a_key_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_key_out != '0) |->
            (o_centre_x == '0) && (o_centre_y == '0) && (o_centre_z == '0))
        else $error("key and centre both nonzero");

    // an empty output register never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[S_OUT] |-> !o_stall)
        else $error("stall with empty output stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a negative decode key leaves all outputs zero
    a_neg_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_M2] && r_m2.func && r_m2.neg && w_mv[S_OUT] |=>
            (o_key_out == '0) && (o_centre_x == '0) && (o_centre_y == '0)
            && (o_centre_z == '0))
        else $error("negative key decoded to nonzero");
`endif

endmodule

@@ dv/tb_voxel_key_codec_top.sv @@
// testbench for voxel_key_codec_top: random and directed points and keys,
// checked against an in-bench predictor; depends on vkc_pkg and the rtl top
`timescale 1ns / 1ps

module tb_voxel_key_codec_top;

    typedef struct {
        logic        func;
        logic [31:0] px, py, pz, key;
    } t_vox_item;

    typedef struct {
        logic [30:0] key;
        logic [31:0] cx, cy, cz;
    } t_vox_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [vkc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [vkc_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_func = 1'b0;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0, i_key_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [30:0] o_key_out;
    logic signed [31:0] o_centre_x, o_centre_y, o_centre_z;

    voxel_key_codec_top DUT (.*);

    // grid settings mirrored from the register writes
    longint org[3];
    longint vsz[3];
    longint gstep;

    t_vox_item pending_items[$];
    t_vox_res  expected_results[$];
    int  fail_count = 0;
    bit  idle_en = 1'b1;
    bit  hold_send = 1'b0;
    bit  in_wait = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    // voxel index of one axis, rounded half away from zero and clamped
    function automatic longint voxel_index(longint p, longint o, longint s, longint r);
        longint d, q;
        d = p - o;
        if (d <= 0) return 0;
        q = (2 * d + s) / (2 * s);
        return (q > r - 1) ? r - 1 : q;
    endfunction

    // voxel centre of one axis, saturated to 32 bits
    function automatic logic [31:0] voxel_centre(longint idx, longint s, longint o);
        longint v;
        v = (((2 * idx + 1) * s + 1) >>> 1) + o;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_vox_res predict_codec(t_vox_item it);
        t_vox_res rs;
        longint r, s[3], k, ix, iy, iz;
        r = ((gstep < 1) ? 1 : (gstep > 1023) ? 1023 : gstep) + 100;
        for (int a = 0; a < 3; a++) s[a] = (vsz[a] == 0) ? 1 : vsz[a];
        rs = '{default: '0};
        if (!it.func) begin
            ix = voxel_index(longint'($signed(it.px)), org[0], s[0], r);
            iy = voxel_index(longint'($signed(it.py)), org[1], s[1], r);
            iz = voxel_index(longint'($signed(it.pz)), org[2], s[2], r);
            k = ix * r * r + iy * r + iz;
            rs.key = k[30:0];
        end else begin
            k = longint'($signed(it.key));
            if (k >= 0) begin
                rs.cx = voxel_centre(k / (r * r), s[0], org[0]);
                rs.cy = voxel_centre((k / r) % r, s[1], org[1]);
                rs.cz = voxel_centre(k % r, s[2], org[2]);
            end
        end
        return rs;
    endfunction

    // input item still waiting at the last rising edge
    always @(posedge i_clk) begin
        in_wait <= i_valid && o_stall;
    end

    // driver: present items at the falling edge, hold until accepted
    always @(negedge i_clk) begin
        if (i_rst_n && !in_wait) begin
            if (pending_items.size() > 0 && !hold_send &&
                !(idle_en && $urandom_range(99) < 17)) begin
                t_vox_item it;
                it = pending_items.pop_front();
                expected_results = {expected_results, predict_codec(it)};
                i_valid   <= 1'b1;
                i_func    <= it.func;
                i_point_x <= it.px;
                i_point_y <= it.py;
                i_point_z <= it.pz;
                i_key_in  <= it.key;
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (i_rst_n) i_stall <= idle_en && ($urandom_range(99) < 17);
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result key=%h", $time, o_key_out);
                fail_count++;
            end else begin
                t_vox_res e;
                e = expected_results.pop_front();
                if (o_key_out !== e.key) begin
                    $display("%0t: key exp %h got %h", $time, e.key, o_key_out);
                    fail_count++;
                end
                if (o_centre_x !== e.cx) begin
                    $display("%0t: centre_x exp %h got %h", $time, e.cx, o_centre_x);
                    fail_count++;
                end
                if (o_centre_y !== e.cy) begin
                    $display("%0t: centre_y exp %h got %h", $time, e.cy, o_centre_y);
                    fail_count++;
                end
                if (o_centre_z !== e.cz) begin
                    $display("%0t: centre_z exp %h got %h", $time, e.cz, o_centre_z);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // register write at a falling edge, taken at the next rising edge
    task automatic write_reg(logic [vkc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            vkc_pkg::REG_ORIGIN_X: org[0] = longint'($signed(val));
            vkc_pkg::REG_ORIGIN_Y: org[1] = longint'($signed(val));
            vkc_pkg::REG_ORIGIN_Z: org[2] = longint'($signed(val));
            vkc_pkg::REG_SIZE_X:   vsz[0] = val[30:0];
            vkc_pkg::REG_SIZE_Y:   vsz[1] = val[30:0];
            vkc_pkg::REG_SIZE_Z:   vsz[2] = val[30:0];
            vkc_pkg::REG_STEP:     gstep  = val[9:0];
            default: ;
        endcase
        repeat (3) @(negedge i_clk);
    endtask

    task automatic add_item(logic f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] k);
        t_vox_item it;
        it.func = f; it.px = x; it.py = y; it.pz = z; it.key = k;
        pending_items = {pending_items, it};
    endtask

    // random point near the grid most of the time, anywhere otherwise
    function automatic logic [31:0] rand_coord(int a);
        longint v;
        if ($urandom_range(9) < 7) begin
            v = org[a] + longint'($urandom_range(140)) * vsz[a] / 2
                - longint'($urandom_range(2)) * vsz[a] + $signed($urandom_range(8)) - 4;
            return v[31:0];
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_key();
        longint r;
        r = ((gstep < 1) ? 1 : gstep) + 100;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h7fffffff);
            default: return $urandom_range(32'(r * r * r + r * r));
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1))
                add_item(1'b0, rand_coord(0), rand_coord(1), rand_coord(2), 32'h0);
            else
                add_item(1'b1, $urandom, $urandom, $urandom, rand_key());
        end
    endtask

    initial begin
        org = '{0, 0, 0};
        vsz = '{65536, 65536, 65536};
        gstep = 64;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both operations, negative key, rounding ties
        add_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_item(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        add_item(1'b0, 32'h00008000, 32'h00018000, 32'h00007fff, 32'h0);
        add_item(1'b0, 32'h00a40000, 32'h00a38000, 32'hffff8000, 32'h0);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
        add_item(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h80000000);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'd5088447);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'd5088448);
        wait_drained();

        // big sizes and extreme origins: saturation both ways
        write_reg(vkc_pkg::REG_ORIGIN_X, 32'h7fffffff);
        write_reg(vkc_pkg::REG_ORIGIN_Y, 32'h80000000);
        write_reg(vkc_pkg::REG_ORIGIN_Z, 32'h0);
        write_reg(vkc_pkg::REG_SIZE_X, 32'h7fffffff);
        write_reg(vkc_pkg::REG_SIZE_Y, 32'h7fffffff);
        write_reg(vkc_pkg::REG_SIZE_Z, 32'h1);
        write_reg(vkc_pkg::REG_STEP, 32'd1023);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'd12345);
        add_item(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
        add_item(1'b0, 32'h80000000, 32'h80000000, 32'h00000400, 32'h0);
        random_phase(300);
        wait_drained();

        // zero sizes and zero step (treated as smallest)
        write_reg(vkc_pkg::REG_SIZE_X, 32'h0);
        write_reg(vkc_pkg::REG_SIZE_Y, 32'h80000000);
        write_reg(vkc_pkg::REG_SIZE_Z, 32'd3);
        write_reg(vkc_pkg::REG_STEP, 32'd0);
        write_reg(vkc_pkg::REG_ORIGIN_X, 32'hfffffff0);
        add_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
        random_phase(300);

        // sender holds off until the pipeline is empty
        hold_send = 1'b1;
        while (expected_results.size() > 0) @(posedge i_clk);
        hold_send = 1'b0;
        wait_drained();

        // no idling on either side
        idle_en = 1'b0;
        write_reg(vkc_pkg::REG_STEP, 32'h3ff);
        write_reg(vkc_pkg::REG_SIZE_X, 32'd40000);
        write_reg(vkc_pkg::REG_SIZE_Y, 32'd70000);
        write_reg(vkc_pkg::REG_SIZE_Z, 32'd1 << 20);
        write_reg(vkc_pkg::REG_ORIGIN_Y, 32'hfff00000);
        write_reg(vkc_pkg::REG_ORIGIN_Z, 32'h00200000);
        random_phase(400);
        wait_drained();
        idle_en = 1'b1;

        // several random settings
        for (int p = 0; p < 3; p++) begin
            write_reg(vkc_pkg::REG_ORIGIN_X, $urandom);
            write_reg(vkc_pkg::REG_ORIGIN_Y,
                      $signed($urandom_range(32'h00ffffff)) - 32'sh00800000);
            write_reg(vkc_pkg::REG_ORIGIN_Z, $urandom_range(32'h000fffff));
            write_reg(vkc_pkg::REG_SIZE_X, $urandom_range(32'h0003ffff, 1));
            write_reg(vkc_pkg::REG_SIZE_Y, $urandom);
            write_reg(vkc_pkg::REG_SIZE_Z, $urandom_range(32'h000fffff, 1));
            write_reg(vkc_pkg::REG_STEP, $urandom_range(1023, 1));
            random_phase(300);
            wait_drained();
        end

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
